FILE: rtl/core/citl_pkg.sv
// ----------------------------------------------------------------------------
// citl_pkg: shared types and constants for the cached interval table lookup
// Result record, compare flags, command codes and default sizes.
// ----------------------------------------------------------------------------
package citl_pkg;

  localparam int SLOT_W          = 10;
  localparam int CNT_W           = 11;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  // upper bound of the gap recorded past the last entry
  localparam logic [63:0] TAIL_GAP_END = 64'h0000_0000_7FFF_FFFF;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              has_entry;
    logic [SLOT_W-1:0] entry_slot;
    logic              selection_changed;
    logic              search_error;
  } res_t;

  typedef struct packed {
    logic gt_low;   // key above low bound
    logic lt_high;  // key below high bound
  } cmp_t;

  function automatic res_t mk_res(input logic has, input logic [SLOT_W-1:0] slot,
                                  input logic changed, input logic err);
    res_t r;
    r.has_entry         = has;
    r.entry_slot        = has ? slot : '0;
    r.selection_changed = changed;
    r.search_error      = err;
    return r;
  endfunction

endpackage

FILE: rtl/core/citl_cmp.sv
// ----------------------------------------------------------------------------
// citl_cmp: shared bound compare unit
// Compares the query key against a low and a high bound, both exclusive.
// ----------------------------------------------------------------------------
module citl_cmp #(
  parameter int KEY_WIDTH = citl_pkg::DEF_KEY_WIDTH
) (
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [KEY_WIDTH-1:0] low_bound,
  input  logic [KEY_WIDTH-1:0] high_bound,
  output citl_pkg::cmp_t       flags
);
  import citl_pkg::*;

  assign flags.gt_low  = key > low_bound;
  assign flags.lt_high = key < high_bound;

endmodule

FILE: rtl/core/citl_seq.sv
// ----------------------------------------------------------------------------
// citl_seq: table memory and lookup sequencer
// Holds the interval table and steps one query through cache check,
// neighbor check and binary search using one read port and one compare unit.
// ----------------------------------------------------------------------------
module citl_seq #(
  parameter int TABLE_DEPTH = citl_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = citl_pkg::DEF_KEY_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [citl_pkg::SLOT_W-1:0]  entry_index,
  input  logic [KEY_WIDTH-1:0]         entry_start,
  input  logic [KEY_WIDTH-1:0]         entry_end,
  input  logic [KEY_WIDTH-1:0]         query_key,
  input  logic [citl_pkg::CNT_W-1:0]   entry_count,
  output logic                         res_valid,
  input  logic                         res_ready,
  output citl_pkg::res_t               res
);
  import citl_pkg::*;

  localparam int KW = KEY_WIDTH;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = NW + 1;
  localparam logic signed [SW-1:0] IDX_ONE = SW'(1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CACHE = 4'd1;
  localparam logic [3:0] ST_CUR   = 4'd2;
  localparam logic [3:0] ST_NEAR  = 4'd3;
  localparam logic [3:0] ST_NB1   = 4'd4;
  localparam logic [3:0] ST_GAP   = 4'd5;
  localparam logic [3:0] ST_COVN  = 4'd6;
  localparam logic [3:0] ST_SINIT = 4'd7;
  localparam logic [3:0] ST_SCHK  = 4'd8;
  localparam logic [3:0] ST_TAIL  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [2*KW-1:0]        mem [TABLE_DEPTH];
  logic [2*KW-1:0]        rd_data;
  logic [KW-1:0]          rd_start, rd_end;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;

  logic [3:0]             state;
  logic [KW-1:0]          key_q, gap_low, gap_high, sav;
  logic [AW-1:0]          cursor;
  logic                   entry_selected, gh_from_rd, near_pass;
  logic signed [SW-1:0]   lo, hi, lo_next, hi_next, c_ext;

  logic [NW-1:0]          n;
  logic [NW:0]            cur_inc, mid_sum;
  logic                   near_ok;
  logic [AW-1:0]          c_first, c_next;
  logic [KW-1:0]          op_low, op_high, tail_end;
  cmp_t                   cr;
  logic                   hit, gap_hit;

  assign n        = (32'(entry_count) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                           : NW'(entry_count);
  assign cur_inc  = (NW+1)'(cursor) + 1'b1;
  assign near_ok  = cur_inc < (NW+1)'(n);
  assign c_first  = AW'(n >> 1);
  assign tail_end = KW'(TAIL_GAP_END);

  assign rd_start = rd_data[2*KW-1:KW];
  assign rd_end   = rd_data[KW-1:0];

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_FIN);

  // next search window, taken only when the probe misses
  assign c_ext   = signed'(SW'(cursor));
  assign lo_next = cr.lt_high ? lo : c_ext + IDX_ONE;
  assign hi_next = cr.lt_high ? c_ext - IDX_ONE : hi;
  assign mid_sum = (NW+1)'(lo_next[NW-1:0]) + (NW+1)'(hi_next[NW-1:0]) + 1'b1;
  assign c_next  = AW'(mid_sum >> 1);

  // compare operands
  always_comb begin
    op_low  = rd_end;
    op_high = rd_start;
    case (state)
      ST_CACHE: begin
        op_low  = gap_low;
        op_high = gap_high;
      end
      ST_GAP: begin
        op_low  = gh_from_rd ? sav : rd_end;
        op_high = gh_from_rd ? rd_start : sav;
      end
      default: ;
    endcase
  end

  citl_cmp #(.KEY_WIDTH(KW)) u_cmp (
    .key        (key_q),
    .low_bound  (op_low),
    .high_bound (op_high),
    .flags      (cr)
  );

  assign hit     = !cr.gt_low && !cr.lt_high;
  assign gap_hit = cr.gt_low && cr.lt_high;

  // read port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cursor;
    case (state)
      ST_CACHE, ST_NEAR: rd_en = 1'b1;
      ST_NB1: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cur_inc);
      end
      ST_SINIT: begin
        rd_en   = 1'b1;
        rd_addr = c_first;
      end
      ST_SCHK: begin
        rd_en   = !hit && (hi_next >= lo_next);
        rd_addr = c_next;
      end
      ST_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = cr.lt_high ? (cursor - 1'b1) : AW'(cur_inc);
      end
      default: ;
    endcase
  end

  assign wr_en   = (state == ST_IDLE) && in_valid && (cmd == CMD_LOAD) &&
                   (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {entry_start, entry_end};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cursor         <= '0;
      entry_selected <= 1'b0;
      gap_low        <= '1;
      gap_high       <= '1;
      key_q          <= '0;
      sav            <= '0;
      gh_from_rd     <= 1'b0;
      near_pass      <= 1'b0;
      lo             <= '0;
      hi             <= '0;
      res            <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && (cmd == CMD_QUERY)) begin
            key_q <= query_key;
            state <= ST_CACHE;
          end
        end
        ST_CACHE: begin
          if (n == '0) begin
            res   <= mk_res(entry_selected, SLOT_W'(cursor), 1'b0, 1'b0);
            state <= ST_FIN;
          end else if (entry_selected) begin
            state <= ST_CUR;
          end else if (gap_hit) begin
            res   <= mk_res(1'b0, '0, 1'b0, 1'b0);
            state <= ST_FIN;
          end else begin
            state <= ST_NEAR;
          end
        end
        ST_CUR: begin
          if (hit) begin
            res   <= mk_res(1'b1, SLOT_W'(cursor), 1'b0, 1'b0);
            state <= ST_FIN;
          end else begin
            state <= ST_NEAR;
          end
        end
        ST_NEAR: begin
          if (key_q == '0) begin
            entry_selected <= 1'b0;
            res            <= mk_res(1'b0, '0, 1'b1, 1'b0);
            state          <= ST_FIN;
          end else if (near_ok) begin
            state <= ST_NB1;
          end else begin
            state <= ST_SINIT;
          end
        end
        ST_NB1: begin
          sav        <= rd_end;
          gh_from_rd <= 1'b1;
          near_pass  <= 1'b1;
          state      <= ST_GAP;
        end
        ST_GAP: begin
          if (gap_hit) begin
            gap_low        <= op_low;
            gap_high       <= op_high;
            entry_selected <= 1'b0;
            res            <= mk_res(1'b0, '0, 1'b1, 1'b0);
            state          <= ST_FIN;
          end else if (near_pass) begin
            cursor         <= cursor + 1'b1;
            entry_selected <= 1'b1;
            state          <= ST_COVN;
          end else begin
            entry_selected <= 1'b0;
            res            <= mk_res(1'b0, '0, 1'b1, 1'b1);
            state          <= ST_FIN;
          end
        end
        ST_COVN: begin
          if (hit) begin
            res   <= mk_res(1'b1, SLOT_W'(cursor), 1'b1, 1'b0);
            state <= ST_FIN;
          end else begin
            state <= ST_SINIT;
          end
        end
        ST_SINIT: begin
          lo             <= '0;
          hi             <= signed'(SW'(n)) - IDX_ONE;
          cursor         <= c_first;
          entry_selected <= 1'b1;
          state          <= ST_SCHK;
        end
        ST_SCHK: begin
          if (hit) begin
            res   <= mk_res(1'b1, SLOT_W'(cursor), 1'b1, 1'b0);
            state <= ST_FIN;
          end else begin
            lo <= lo_next;
            hi <= hi_next;
            if (hi_next >= lo_next) begin
              cursor <= c_next;
            end else begin
              state <= ST_TAIL;
            end
          end
        end
        ST_TAIL: begin
          // rd_data still holds the last probed entry
          if (cr.lt_high) begin
            if (cursor == '0) begin
              gap_low        <= key_q - 1'b1;
              gap_high       <= rd_start;
              entry_selected <= 1'b0;
              res            <= mk_res(1'b0, '0, 1'b1, 1'b0);
              state          <= ST_FIN;
            end else begin
              cursor     <= cursor - 1'b1;
              sav        <= rd_start;
              gh_from_rd <= 1'b0;
              near_pass  <= 1'b0;
              state      <= ST_GAP;
            end
          end else if (cr.gt_low) begin
            if (!near_ok) begin
              gap_low        <= rd_end;
              gap_high       <= tail_end;
              entry_selected <= 1'b0;
              res            <= mk_res(1'b0, '0, 1'b1, 1'b0);
              state          <= ST_FIN;
            end else begin
              sav        <= rd_end;
              gh_from_rd <= 1'b1;
              near_pass  <= 1'b0;
              state      <= ST_GAP;
            end
          end else begin
            entry_selected <= 1'b0;
            res            <= mk_res(1'b0, '0, 1'b1, 1'b1);
            state          <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_hit_matches_cursor: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.has_entry |-> entry_selected && (res.entry_slot == SLOT_W'(cursor)))
    else $error("reported slot does not match the selected entry");

  a_error_is_change: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.search_error |-> res.selection_changed && !res.has_entry)
    else $error("search error without a selection change");

  a_window_open: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCHK |-> (hi >= lo) && ((NW+1)'(cursor) < (NW+1)'(n)))
    else $error("probe outside the search window");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && in_valid && cmd == CMD_LOAD |=> state == ST_IDLE)
    else $error("load beat started a lookup");

endmodule

FILE: rtl/core/cached_interval_table_lookup_core.sv
// ----------------------------------------------------------------------------
// cached_interval_table_lookup_core: interval table with cached lookup
// Input channel (in_valid/in_ready) carries load beats (cmd 0), which write
// one table slot, and query beats (cmd 1), which look up query_key. A load
// beat is taken while the block is idle and gives no result. A query gives
// exactly one result beat on the output channel (out_valid/out_ready).
// A query is settled by the cached gap or entry, or the table being empty,
// else by the neighboring gap or entry, else by the binary search; one
// table read port and one compare unit are stepped once per cycle, and the
// search takes one probe per cycle. One item is in work at a time, and
// in_ready is low until its result is handed to the output register.
// The output register lets the next item start while a result waits; a
// stalled receiver holds the block once a second result is ready.
// The config channel (cfg_valid/cfg_ready/cfg_data) sets entry_count; it is
// always ready. The user writes it only while the block is idle (not enforced).
// Reset clears the selection, the cursor, the count and sets the cached gap
// to all ones; the table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module cached_interval_table_lookup_core #(
  parameter int TABLE_DEPTH = citl_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = citl_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [citl_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [citl_pkg::SLOT_W-1:0] entry_index,
  input  logic [KEY_WIDTH-1:0]        entry_start,
  input  logic [KEY_WIDTH-1:0]        entry_end,
  input  logic [KEY_WIDTH-1:0]        query_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        has_entry,
  output logic [citl_pkg::SLOT_W-1:0] entry_slot,
  output logic                        selection_changed,
  output logic                        search_error
);
  import citl_pkg::*;

  logic [CNT_W-1:0] entry_count;
  logic             res_valid, res_ready;
  res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  citl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entry_index (entry_index),
    .entry_start (entry_start),
    .entry_end   (entry_end),
    .query_key   (query_key),
    .entry_count (entry_count),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register frees the sequencer while the result beat waits
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      has_entry         <= res.has_entry;
      entry_slot        <= res.entry_slot;
      selection_changed <= res.selection_changed;
      search_error      <= res.search_error;
    end
  end

endmodule
